/* rtl/dpvp_pkg.sv */
// ----------------------------------------------------------------------------
// dpvp_pkg
// Constants and helpers for the dew point from vapor pressure pipeline.
// ----------------------------------------------------------------------------
package dpvp_pkg;

  localparam int PW      = 20;   // input sample width
  localparam int FB      = 32;   // log2 fraction bits
  localparam int LW      = FB + 5;  // log2 width, Q5.32
  localparam int DW      = 45;   // denominator width
  localparam int NW      = 60;   // numerator magnitude width
  localparam int QW      = 17;   // quotient width
  localparam int RW      = 62;   // divider remainder width

  localparam logic [PW-1:0] P_THRESH = PW'(6110);
  localparam logic [31:0]   LN2_Q32  = 32'd2977044472;
  localparam logic [22:0]   NUM_WATER = 23'(256 * 23730);
  localparam logic [22:0]   NUM_ICE   = 23'(256 * 26550);
  localparam logic [11:0]   DEN_WATER = 12'd1727;
  localparam logic [11:0]   DEN_ICE   = 12'd2187;

  // log2 in Q5.32, squaring method with floored squares; elaboration only
  function automatic logic [LW-1:0] log2_q32(input logic [31:0] x);
    logic [4:0]  k;
    logic [63:0] m;
    logic [31:0] f;
    k = '0;
    f = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) k = 5'(i);
    end
    m = 64'(x) << (31 - k);
    for (int i = 1; i <= 32; i++) begin
      m = (m * m) >> 31;
      if (m[32]) begin
        m = m >> 1;
        f[32 - i] = 1'b1;
      end
    end
    return {k, f};
  endfunction

  localparam logic [LW-1:0] LOG2_THRESH = log2_q32(32'(P_THRESH));

endpackage

/* rtl/dew_point_from_vapor_pressure_core.sv */
// ----------------------------------------------------------------------------
// dew_point_from_vapor_pressure_core
// Inverted Magnus dew point from a vapor pressure sample, fully pipelined.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)            tuser
// s_*      in   vapor_pressure[19:0], pad 0   -
// m_*      out  dew_point[15:0] (signed)      valid_res
//
// One item per cycle unless the output stalls. Stages: input/normalize, 32 log2
// squaring stages, 5 stages of threshold difference, ln2 scaling, operand setup
// and rounding bias, 17 divider stages and the output register.
// Reset (rst, synchronous) clears every stage valid bit; data needs none.
// The whole pipeline advances when the output register is empty or taken,
// so a stall holds every stage in place and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module dew_point_from_vapor_pressure_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // vapor_pressure[19:0], zeros above
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // dew_point[15:0]
  output logic        m_tuser    // valid_res
);
  import dpvp_pkg::*;

  localparam int NSQ = 32;
  localparam int NDV = QW;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---------------- normalize: leading one and Q1.31 mantissa
  logic [PW-1:0] in_p;
  logic [4:0]    in_k;
  always_comb begin
    in_p = s_tdata[PW-1:0];
    in_k = '0;
    for (int i = 0; i < PW; i++) begin
      if (in_p[i]) in_k = 5'(i);
    end
  end

  logic          sq_v [0:NSQ];
  logic [31:0]   sq_m [0:NSQ];
  logic [31:0]   sq_f [0:NSQ];
  logic [4:0]    sq_k [0:NSQ];
  logic [PW-1:0] sq_p [0:NSQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= s_tvalid;
    end
    if (adv) begin
      sq_m[0] <= 32'(in_p) << (5'd31 - in_k);
      sq_f[0] <= '0;
      sq_k[0] <= in_k;
      sq_p[0] <= in_p;
    end
  end

  // ---------------- log2 fraction: one squaring per stage
  for (genvar g = 1; g <= NSQ; g++) begin : g_sq
    logic [63:0] prod;
    logic [32:0] msq;
    assign prod = 64'(sq_m[g-1]) * 64'(sq_m[g-1]);
    assign msq  = prod[63:31];
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[g] <= 1'b0;
      end else if (adv) begin
        sq_v[g] <= sq_v[g-1];
      end
      if (adv) begin
        sq_m[g] <= msq[32] ? msq[32:1] : msq[31:0];
        sq_f[g] <= sq_f[g-1] | (msq[32] ? (32'd1 << (32 - g)) : 32'd0);
        sq_k[g] <= sq_k[g-1];
        sq_p[g] <= sq_p[g-1];
      end
    end
  end

  // ---------------- difference against threshold, magnitude split
  logic [LW:0]   a_d;
  logic          a_neg;
  logic [LW:0]   a_mag;
  assign a_d   = {1'b0, sq_k[NSQ], sq_f[NSQ]} - {1'b0, LOG2_THRESH};
  assign a_neg = a_d[LW];
  assign a_mag = a_neg ? (~a_d + 1'b1) : a_d;

  logic          b_v, b_neg;
  logic [4:0]    b_hi;
  logic [31:0]   b_lo;
  logic [PW-1:0] b_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= sq_v[NSQ];
    end
    if (adv) begin
      b_neg <= a_neg;
      b_hi  <= a_mag[36:32];
      b_lo  <= a_mag[31:0];
      b_p   <= sq_p[NSQ];
    end
  end

  // ---------------- ln2 scaling products
  logic          c_v, c_neg;
  logic [63:0]   c_plo;
  logic [36:0]   c_phi;
  logic [PW-1:0] c_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_v;
    end
    if (adv) begin
      c_neg <= b_neg;
      c_plo <= 64'(b_lo) * 64'(LN2_Q32);
      c_phi <= 37'(b_hi) * 37'(LN2_Q32);
      c_p   <= b_p;
    end
  end

  // ---------------- L magnitude, Q.32
  logic          d_v, d_neg;
  logic [36:0]   d_lm;
  logic [PW-1:0] d_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= c_v;
    end
    if (adv) begin
      d_neg <= c_neg;
      d_lm  <= c_phi + 37'(c_plo[63:32]);
      d_p   <= c_p;
    end
  end

  // ---------------- numerator magnitude and denominator
  logic          e_water;
  logic [22:0]   e_cn;
  logic [DW-1:0] e_base, e_l100;
  assign e_water = d_p > P_THRESH;
  assign e_cn    = e_water ? NUM_WATER : NUM_ICE;
  assign e_base  = DW'({(e_water ? DEN_WATER : DEN_ICE), 32'd0});
  assign e_l100  = DW'(d_lm) * DW'(100);

  logic          e_v, e_neg;
  logic [NW-1:0] e_num;
  logic [DW-1:0] e_den;
  logic [PW-1:0] e_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= d_v;
    end
    if (adv) begin
      e_neg <= d_neg;
      e_num <= NW'(d_lm) * NW'(e_cn);
      e_den <= d_neg ? (e_base + e_l100) : (e_base - e_l100);
      e_p   <= d_p;
    end
  end

  // ---------------- rounding bias, divider entry
  logic          dv_v   [0:NDV];
  logic          dv_neg [0:NDV];
  logic [RW-1:0] dv_r   [0:NDV];
  logic [DW-1:0] dv_den [0:NDV];
  logic [QW-1:0] dv_q   [0:NDV];
  logic [PW-1:0] dv_p   [0:NDV];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= e_v;
    end
    if (adv) begin
      dv_neg[0] <= e_neg;
      dv_r[0]   <= RW'(e_num) + RW'(e_den >> 1);
      dv_den[0] <= e_den;
      dv_q[0]   <= '0;
      dv_p[0]   <= e_p;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage
  for (genvar g = 1; g <= NDV; g++) begin : g_dv
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(dv_den[g-1]) << (NDV - g);
    assign ge  = dv_r[g-1] >= dsh;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[g] <= 1'b0;
      end else if (adv) begin
        dv_v[g] <= dv_v[g-1];
      end
      if (adv) begin
        dv_neg[g] <= dv_neg[g-1];
        dv_r[g]   <= ge ? (dv_r[g-1] - dsh) : dv_r[g-1];
        dv_den[g] <= dv_den[g-1];
        dv_q[g]   <= dv_q[g-1] | (ge ? (QW'(1) << (NDV - g)) : QW'(0));
        dv_p[g]   <= dv_p[g-1];
      end
    end
  end

  // ---------------- sign, saturation, zero-pressure case
  logic signed [QW:0] f_t;
  logic [15:0]        f_dp;
  always_comb begin
    f_t = dv_neg[NDV] ? -$signed({1'b0, dv_q[NDV]}) : $signed({1'b0, dv_q[NDV]});
    if (f_t > 18'sd32767) begin
      f_dp = 16'h7fff;
    end else if (f_t < -18'sd32768) begin
      f_dp = 16'h8000;
    end else begin
      f_dp = f_t[15:0];
    end
    if (dv_p[NDV] == '0) begin
      f_dp = 16'h8000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_v[NDV];
    end
    if (adv) begin
      m_tdata <= f_dp;
      m_tuser <= dv_p[NDV] != '0;
    end
  end

  // ---------------- checks
  a_zero_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 16'h8000)
    else $error("zero pressure item without -32768 code");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> $signed(m_tdata) >= -16'sd20000 &&
                            $signed(m_tdata) <= 16'sd26500)
    else $error("dew point outside physical range of 20-bit input");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && !sq_v[0])
    else $error("valid survives reset");

endmodule
